### rtl/ytpd_pkg.sv
`timescale 1ns / 1ps

package ytpd_pkg;

    localparam int LUMA_W  = 8;
    localparam int INDEX_W = 8;
    localparam int DELTA_W = 11;
    localparam int SUM_W   = 12;
    localparam int PROD_W  = 27;
    localparam int TH_W    = 6;
    localparam int LEVEL_W = 3;
    localparam int LANES   = 4;

    localparam logic signed [PROD_W-1:0] Y_SCALE = 27'sd76309;
    localparam logic signed [PROD_W-1:0] CR_TO_R = 27'sd104597;
    localparam logic signed [PROD_W-1:0] CB_TO_G = 27'sd25674;
    localparam logic signed [PROD_W-1:0] CR_TO_G = 27'sd53278;
    localparam logic signed [PROD_W-1:0] CB_TO_B = 27'sd132201;

    localparam logic [TH_W-1:0] DITHER_TH [LANES] = '{6'd0, 6'd25, 6'd38, 6'd13};

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    // clamp to 0..255, add threshold, level = floor(x/51) capped at 5
    function automatic logic [LEVEL_W-1:0] quant_level(
        input logic signed [SUM_W-1:0] v,
        input logic [TH_W-1:0] th
    );
        logic [LUMA_W-1:0] c;
        logic [LUMA_W:0]   x;
        logic [LEVEL_W-1:0] lv;
        if (v < 0)
            c = '0;
        else if (v > 12'sd255)
            c = 8'd255;
        else
            c = v[LUMA_W-1:0];
        x = 9'(c) + 9'(th);
        if (x >= 9'd255)
            lv = 3'd5;
        else if (x >= 9'd204)
            lv = 3'd4;
        else if (x >= 9'd153)
            lv = 3'd3;
        else if (x >= 9'd102)
            lv = 3'd2;
        else if (x >= 9'd51)
            lv = 3'd1;
        else
            lv = 3'd0;
        return lv;
    endfunction

    function automatic logic [INDEX_W-1:0] palette_index(
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b
    );
        return INDEX_W'(r) * 8'd36 + INDEX_W'(g) * 8'd6 + INDEX_W'(b);
    endfunction

endpackage

### rtl/ycbcr_to_palette_dither_unit.sv
`timescale 1ns / 1ps
// an accepted request moves from the stage-one registers to the output register, and its
// indices show at out_valid; throughput: one 2x2 block per clock unless out_stall holds it;
// stage one registers chroma deltas and expanded luma, four lanes quantise, the output register merges them
// reset: rst_n asynchronously clears both stage valid flags; data registers are not reset
// in_stall rises only when both stages hold requests and the output is stalled

module ycbcr_to_palette_dither_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ytpd_pkg::LUMA_W-1:0]   luma_top_left,
    input  logic [ytpd_pkg::LUMA_W-1:0]   luma_top_right,
    input  logic [ytpd_pkg::LUMA_W-1:0]   luma_bottom_left,
    input  logic [ytpd_pkg::LUMA_W-1:0]   luma_bottom_right,
    input  logic [ytpd_pkg::LUMA_W-1:0]   chroma_blue,
    input  logic [ytpd_pkg::LUMA_W-1:0]   chroma_red,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ytpd_pkg::INDEX_W-1:0]  index_top_left,
    output logic [ytpd_pkg::INDEX_W-1:0]  index_top_right,
    output logic [ytpd_pkg::INDEX_W-1:0]  index_bottom_left,
    output logic [ytpd_pkg::INDEX_W-1:0]  index_bottom_right
);

    ytpd_pkg::stage_en_t                    en;
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic                                   accept;
    logic signed [ytpd_pkg::DELTA_W-1:0]    rd;
    logic signed [ytpd_pkg::DELTA_W-1:0]    gd;
    logic signed [ytpd_pkg::DELTA_W-1:0]    bd;
    logic [ytpd_pkg::LUMA_W-1:0]            luma [ytpd_pkg::LANES];
    logic [ytpd_pkg::INDEX_W-1:0]           lane_index [ytpd_pkg::LANES];
    logic [ytpd_pkg::INDEX_W-1:0]           index_reg [ytpd_pkg::LANES];

    assign en.s2    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !en.s2;
    assign accept   = in_valid && !in_stall;
    assign en.s1    = accept;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (en.s2 ? 1'b0 : s1_valid_reg);
        out_valid_next = en.s2 ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ytpd_chroma u_chroma
    (
        .clk         (clk),
        .en          (en),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .rd          (rd),
        .gd          (gd),
        .bd          (bd)
    );

    assign luma[0] = luma_top_left;
    assign luma[1] = luma_top_right;
    assign luma[2] = luma_bottom_left;
    assign luma[3] = luma_bottom_right;

    for (genvar k = 0; k < ytpd_pkg::LANES; k++)
    begin : g_lane
        ytpd_lane u_lane
        (
            .clk   (clk),
            .en    (en),
            .luma  (luma[k]),
            .th    (ytpd_pkg::DITHER_TH[k]),
            .rd    (rd),
            .gd    (gd),
            .bd    (bd),
            .index (lane_index[k])
        );
    end

    // merging stage: the four lane results land in one output word
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int k = 0; k < ytpd_pkg::LANES; k++)
            begin
                index_reg[k] <= lane_index[k];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign index_top_left     = index_reg[0];
    assign index_top_right    = index_reg[1];
    assign index_bottom_left  = index_reg[2];
    assign index_bottom_right = index_reg[3];

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_request_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("stage one request did not move to the output");

    a_no_phantom_output: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !(out_valid_reg && out_stall)) |=> !out_valid_reg)
        else $error("output valid without a request behind it");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (index_top_left <= 8'd215 && index_top_right <= 8'd215 &&
                       index_bottom_left <= 8'd215 && index_bottom_right <= 8'd215))
        else $error("palette index out of range");

endmodule

### rtl/ytpd_chroma.sv
`timescale 1ns / 1ps

module ytpd_chroma
(
    input  logic                                  clk,
    input  ytpd_pkg::stage_en_t                   en,
    input  logic [ytpd_pkg::LUMA_W-1:0]           chroma_blue,
    input  logic [ytpd_pkg::LUMA_W-1:0]           chroma_red,
    output logic signed [ytpd_pkg::DELTA_W-1:0]   rd,
    output logic signed [ytpd_pkg::DELTA_W-1:0]   gd,
    output logic signed [ytpd_pkg::DELTA_W-1:0]   bd
);

    logic signed [8:0]                      cb;
    logic signed [8:0]                      cr;
    logic signed [ytpd_pkg::PROD_W-1:0]     prod_r;
    logic signed [ytpd_pkg::PROD_W-1:0]     prod_g;
    logic signed [ytpd_pkg::PROD_W-1:0]     prod_b;
    logic signed [ytpd_pkg::DELTA_W-1:0]    rd_reg;
    logic signed [ytpd_pkg::DELTA_W-1:0]    gd_reg;
    logic signed [ytpd_pkg::DELTA_W-1:0]    bd_reg;

    assign cb = $signed({1'b0, chroma_blue}) - 9'sd128;
    assign cr = $signed({1'b0, chroma_red}) - 9'sd128;

    assign prod_r = ytpd_pkg::PROD_W'(cr) * ytpd_pkg::CR_TO_R;
    assign prod_g = ytpd_pkg::PROD_W'(cb) * ytpd_pkg::CB_TO_G
                  + ytpd_pkg::PROD_W'(cr) * ytpd_pkg::CR_TO_G;
    assign prod_b = ytpd_pkg::PROD_W'(cb) * ytpd_pkg::CB_TO_B;

    // taking the upper bits is a floor divide by 2^16
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            rd_reg <= prod_r[ytpd_pkg::PROD_W-1:16];
            gd_reg <= prod_g[ytpd_pkg::PROD_W-1:16];
            bd_reg <= prod_b[ytpd_pkg::PROD_W-1:16];
        end
    end

    assign rd = rd_reg;
    assign gd = gd_reg;
    assign bd = bd_reg;

endmodule

### rtl/ytpd_lane.sv
`timescale 1ns / 1ps

module ytpd_lane
(
    input  logic                                  clk,
    input  ytpd_pkg::stage_en_t                   en,
    input  logic [ytpd_pkg::LUMA_W-1:0]           luma,
    input  logic [ytpd_pkg::TH_W-1:0]             th,
    input  logic signed [ytpd_pkg::DELTA_W-1:0]   rd,
    input  logic signed [ytpd_pkg::DELTA_W-1:0]   gd,
    input  logic signed [ytpd_pkg::DELTA_W-1:0]   bd,
    output logic [ytpd_pkg::INDEX_W-1:0]          index
);

    logic signed [8:0]                      y_off;
    logic signed [ytpd_pkg::PROD_W-1:0]     y_prod;
    logic signed [10:0]                     y_raw;
    logic [ytpd_pkg::LUMA_W-1:0]            y_next;
    logic [ytpd_pkg::LUMA_W-1:0]            y_reg;
    logic signed [ytpd_pkg::SUM_W-1:0]      y_ext;
    logic signed [ytpd_pkg::SUM_W-1:0]      sum_r;
    logic signed [ytpd_pkg::SUM_W-1:0]      sum_g;
    logic signed [ytpd_pkg::SUM_W-1:0]      sum_b;

    assign y_off  = $signed({1'b0, luma}) - 9'sd16;
    assign y_prod = ytpd_pkg::PROD_W'(y_off) * ytpd_pkg::Y_SCALE;
    assign y_raw  = y_prod[26:16];

    always_comb
    begin
        if (y_raw < 0)
            y_next = '0;
        else if (y_raw > 11'sd255)
            y_next = 8'd255;
        else
            y_next = y_raw[ytpd_pkg::LUMA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
            y_reg <= y_next;
    end

    assign y_ext = $signed({4'b0000, y_reg});
    assign sum_r = y_ext + ytpd_pkg::SUM_W'(rd);
    assign sum_g = y_ext - ytpd_pkg::SUM_W'(gd);
    assign sum_b = y_ext + ytpd_pkg::SUM_W'(bd);

    assign index = ytpd_pkg::palette_index(ytpd_pkg::quant_level(sum_r, th),
                                           ytpd_pkg::quant_level(sum_g, th),
                                           ytpd_pkg::quant_level(sum_b, th));

endmodule

### tb/sv/ycbcr_to_palette_dither_unit_test.sv
`timescale 1ns / 1ps

module ycbcr_to_palette_dither_unit_test;

    localparam int LW = ytpd_pkg::LUMA_W;
    localparam int IW = ytpd_pkg::INDEX_W;

    // BT.601 limited-range factors in Q16
    localparam int LUMA_GAIN  = 76309;
    localparam int CR_RED     = 104597;
    localparam int CB_GREEN   = 25674;
    localparam int CR_GREEN   = 53278;
    localparam int CB_BLUE    = 132201;
    localparam int CHAN_TOP   = 255;
    localparam int LEVEL_TOP  = 5;
    localparam int RED_STEP   = 36;
    localparam int GREEN_STEP = 6;
    localparam int CHROMA_MID = 128;
    localparam int LUMA_FLOOR = 16;

    localparam int DOTS [4] = '{0, 25, 38, 13};
    localparam string DOT_NAMES [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

    typedef struct packed {
        logic [3:0][LW-1:0] luma;
        logic [LW-1:0]      cb;
        logic [LW-1:0]      cr;
    } ycc_block_t;

    typedef logic [3:0][IW-1:0] palette_quad_t;

    class palette_scoreboard;
        palette_quad_t expected_q[$];
        int            mismatches;

        function int clamp_chan(int v);
            if (v < 0)
                return 0;
            if (v > CHAN_TOP)
                return CHAN_TOP;
            return v;
        endfunction

        function int chan_level(int v, int th);
            int lv;
            lv = ((clamp_chan(v) + th) * LEVEL_TOP) / CHAN_TOP;
            return (lv > LEVEL_TOP) ? LEVEL_TOP : lv;
        endfunction

        function palette_quad_t palette_of(ycc_block_t b);
            palette_quad_t q;
            int cb;
            int cr;
            int rd;
            int gd;
            int bd;
            int y;
            cb = int'(b.cb) - CHROMA_MID;
            cr = int'(b.cr) - CHROMA_MID;
            // arithmetic shift gives the floor for negative products
            rd = (cr * CR_RED) >>> 16;
            gd = (cb * CB_GREEN + cr * CR_GREEN) >>> 16;
            bd = (cb * CB_BLUE) >>> 16;
            for (int k = 0; k < 4; k++)
            begin
                y = clamp_chan(((int'(b.luma[k]) - LUMA_FLOOR) * LUMA_GAIN) >>> 16);
                q[k] = IW'(chan_level(y + rd, DOTS[k]) * RED_STEP
                         + chan_level(y - gd, DOTS[k]) * GREEN_STEP
                         + chan_level(y + bd, DOTS[k]));
            end
            return q;
        endfunction

        function void note_block(ycc_block_t b);
            expected_q.push_back(palette_of(b));
        endfunction

        function void check_quad(palette_quad_t got);
            palette_quad_t exp_q;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: %0d %0d %0d %0d",
                             got[0], got[1], got[2], got[3]);
                return;
            end
            exp_q = expected_q.pop_front();
            for (int k = 0; k < 4; k++)
            begin
                if (got[k] !== exp_q[k])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("index_%s mismatch: expected %0d, got %0d",
                                 DOT_NAMES[k], exp_q[k], got[k]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (expected_q.size() == 0);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [LW-1:0] luma_top_left;
    logic [LW-1:0] luma_top_right;
    logic [LW-1:0] luma_bottom_left;
    logic [LW-1:0] luma_bottom_right;
    logic [LW-1:0] chroma_blue;
    logic [LW-1:0] chroma_red;
    logic          out_valid;
    logic          out_stall;
    logic [IW-1:0] index_top_left;
    logic [IW-1:0] index_top_right;
    logic [IW-1:0] index_bottom_left;
    logic [IW-1:0] index_bottom_right;

    palette_scoreboard board = new();
    bit send_idle;
    bit take_idle;

    ycbcr_to_palette_dither_unit i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .luma_top_left      (luma_top_left),
        .luma_top_right     (luma_top_right),
        .luma_bottom_left   (luma_bottom_left),
        .luma_bottom_right  (luma_bottom_right),
        .chroma_blue        (chroma_blue),
        .chroma_red         (chroma_red),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .index_top_left     (index_top_left),
        .index_top_right    (index_top_right),
        .index_bottom_left  (index_bottom_left),
        .index_bottom_right (index_bottom_right)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(bit idle);
        int r;
        if (!idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ycc_block_t make_block(int l0, int l1, int l2, int l3, int cb, int cr);
        ycc_block_t b;
        b.luma[0] = LW'(l0);
        b.luma[1] = LW'(l1);
        b.luma[2] = LW'(l2);
        b.luma[3] = LW'(l3);
        b.cb      = LW'(cb);
        b.cr      = LW'(cr);
        return b;
    endfunction

    function automatic logic [LW-1:0] rand_sample(bit chroma);
        int luma_edges [8] = '{0, 15, 16, 17, 234, 235, 236, 255};
        int chroma_edges [8] = '{0, 1, 64, 127, 128, 129, 254, 255};
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return LW'($urandom_range(0, 255));
        if (r < 9)
            return chroma ? LW'(chroma_edges[$urandom_range(0, 7)])
                          : LW'(luma_edges[$urandom_range(0, 7)]);
        return chroma ? LW'($urandom_range(100, 156)) : LW'($urandom_range(0, 24));
    endfunction

    function automatic ycc_block_t rand_block();
        ycc_block_t b;
        for (int k = 0; k < 4; k++)
            b.luma[k] = rand_sample(1'b0);
        b.cb = rand_sample(1'b1);
        b.cr = rand_sample(1'b1);
        return b;
    endfunction

    // entered and left just after a rising edge
    task automatic send_block(ycc_block_t b, int gap);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        luma_top_left     <= b.luma[0];
        luma_top_right    <= b.luma[1];
        luma_bottom_left  <= b.luma[2];
        luma_bottom_right <= b.luma[3];
        chroma_blue       <= b.cb;
        chroma_red        <= b.cr;
        do
            @(negedge clk);
        while (in_stall);
        board.note_block(b);
        @(posedge clk);
    endtask

    // output side: stall pattern and result checks
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(take_idle);
            end
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_quad({index_bottom_right, index_bottom_left,
                                  index_top_right, index_top_left});
        end
    end

    initial
    begin
        send_idle = 1'b0;
        take_idle = 1'b0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        luma_top_left     <= '0;
        luma_top_right    <= '0;
        luma_bottom_left  <= '0;
        luma_bottom_right <= '0;
        chroma_blue       <= '0;
        chroma_red        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_block(make_block(0, 0, 0, 0, 0, 0), 0);
        send_block(make_block(255, 255, 255, 255, 255, 255), 0);
        send_block(make_block(15, 16, 17, 235, 128, 128), 0);
        send_block(make_block(0, 0, 0, 0, 128, 128), 0);
        // strongly negative blue delta pulls blue below zero
        send_block(make_block(128, 128, 128, 128, 0, 128), 0);
        send_block(make_block(128, 128, 128, 128, 255, 128), 0);
        send_block(make_block(128, 128, 128, 128, 128, 0), 0);
        send_block(make_block(128, 128, 128, 128, 128, 255), 0);
        send_block(make_block(200, 200, 200, 200, 0, 0), 0);
        send_block(make_block(60, 60, 60, 60, 255, 255), 0);
        send_block(make_block(250, 250, 250, 250, 128, 128), 0);
        send_block(make_block(220, 225, 210, 230, 128, 128), 0);
        send_block(make_block(16, 235, 128, 64, 90, 170), 0);
        send_block(make_block(235, 235, 235, 235, 255, 0), 0);
        send_block(make_block(16, 16, 16, 16, 0, 255), 0);
        send_block(make_block(255, 0, 255, 0, 127, 129), 0);

        for (int n = 0; n < 1900; n++)
        begin
            if (n % 250 == 0)
            begin
                send_idle = ($urandom_range(0, 2) != 0);
                take_idle = ($urandom_range(0, 2) != 0);
            end
            // let the pipe run dry once with requests outstanding
            if (n == 900)
            begin
                while (board.pending() > 0)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            send_block(rand_block(), pick_gap(send_idle));
        end
        in_valid <= 1'b0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (board.clean())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### ycbcr_to_palette_dither_unit.f
rtl/ytpd_pkg.sv
rtl/ytpd_chroma.sv
rtl/ytpd_lane.sv
rtl/ycbcr_to_palette_dither_unit.sv
tb/sv/ycbcr_to_palette_dither_unit_test.sv
